// File: hw/rtl/command_line_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// Command line tokenizer: assertion macros
// Concurrent checks used by the tokenizer RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define CLT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed: same-cycle implication");
// next-cycle implication
`define CLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed: next-cycle implication");
// condition that must never hold
`define CLT_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tokenizer check failed: forbidden condition");
`else
`define CLT_ASSERT_IMP(label, clk, rst, ante, cons)
`define CLT_ASSERT_NEXT(label, clk, rst, ante, cons)
`define CLT_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: hw/rtl/clt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Byte codes, status codes, limits and the per-byte result record.
// ----------------------------------------------------------------------------
package clt_pkg;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   localparam int          LINE_BYTES_DEFAULT = 32;
   localparam logic [3:0]  MAX_ARGS_RESET     = 4'd11;
   localparam logic [3:0]  ARG_COUNT_MAX      = 4'd15;
   localparam logic [5:0]  BYTE_COUNT_MAX     = 6'd63;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OPEN     = 2'd1,
      ST_TOO_MANY = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] out_char;
      logic       arg_end;
      logic       line_end;
      status_type status;
      logic [3:0] arg_count;
   } result_type;

endpackage

// File: hw/rtl/clt_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer channels
// Valid/ready interfaces for the byte stream and the per-byte results.
// ----------------------------------------------------------------------------
interface clt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, in_byte, last_byte, input ready);
   modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface clt_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [7:0] out_char;
   logic       arg_end;
   logic       line_end;
   logic [1:0] status;
   logic [3:0] arg_count;

   modport source (output valid, char_valid, out_char, arg_end, line_end, status,
                   arg_count, input ready);
   modport sink   (input valid, char_valid, out_char, arg_end, line_end, status,
                   arg_count, output ready);
endinterface

// File: hw/rtl/clt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer core
// Quote/escape state, argument and byte counters, and the per-byte result.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_defines.svh"

module clt_core #(
   parameter int LINE_BYTES = clt_pkg::LINE_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [7:0]         in_byte,
   input  logic               last_byte,
   input  logic [3:0]         max_args,
   output clt_pkg::result_type result
);
   import clt_pkg::*;

   localparam logic [5:0] LONG_LIMIT = 6'(LINE_BYTES);

   logic       esc_ff, esc_in;
   logic       sq_ff, sq_in;
   logic       dq_ff, dq_in;
   logic       open_ff, open_in;
   logic [3:0] args_ff, args_in;
   logic [5:0] bytes_ff, bytes_in;
   logic       many_ff, many_in;

   logic       esc_mid, sq_mid, dq_mid, open_mid, many_mid;
   logic       keep, space_hit, space_close, last_close, close, open_q;
   logic [3:0] args_mid;
   logic [5:0] bytes_mid;
   status_type status;

   always_comb begin
      esc_mid   = esc_ff;
      sq_mid    = sq_ff;
      dq_mid    = dq_ff;
      keep      = 1'b0;
      space_hit = 1'b0;
      if (esc_ff) begin
         keep    = 1'b1;
         esc_mid = 1'b0;
      end else if (sq_ff) begin
         if (in_byte == CH_SQUOTE) sq_mid = 1'b0;
         else keep = 1'b1;
      end else if (dq_ff) begin
         if (in_byte == CH_DQUOTE) dq_mid = 1'b0;
         else if (in_byte == CH_BSLASH) esc_mid = 1'b1;
         else keep = 1'b1;
      end else if (in_byte == CH_BSLASH) begin
         esc_mid = 1'b1;
      end else if (in_byte == CH_SQUOTE) begin
         sq_mid = 1'b1;
      end else if (in_byte == CH_DQUOTE) begin
         dq_mid = 1'b1;
      end else if (in_byte == CH_SPACE) begin
         space_hit = 1'b1;
      end else begin
         keep = 1'b1;
      end

      bytes_mid   = (bytes_ff == BYTE_COUNT_MAX) ? bytes_ff : bytes_ff + 6'd1;
      space_close = space_hit && open_ff;
      open_mid    = space_close ? 1'b0 : (keep ? 1'b1 : open_ff);
      open_q      = esc_mid || sq_mid || dq_mid;
      last_close  = last_byte && !open_q && open_mid;
      close       = space_close || last_close;
      many_mid    = many_ff || (close && (args_ff >= max_args));
      args_mid    = (close && (args_ff != ARG_COUNT_MAX)) ? args_ff + 4'd1 : args_ff;
      if (last_close) open_mid = 1'b0;

      status = ST_OK;
      if (last_byte) begin
         if (bytes_mid >= LONG_LIMIT) status = ST_TOO_LONG;
         else if (open_q) status = ST_OPEN;
         else if (many_mid) status = ST_TOO_MANY;
      end

      result.char_valid = keep;
      result.out_char   = keep ? in_byte : 8'd0;
      result.arg_end    = close;
      result.line_end   = last_byte;
      result.status     = status;
      result.arg_count  = args_mid;
   end

   // advance the state on every step; drop everything at line end
   always_comb begin
      esc_in   = esc_ff;
      sq_in    = sq_ff;
      dq_in    = dq_ff;
      open_in  = open_ff;
      args_in  = args_ff;
      bytes_in = bytes_ff;
      many_in  = many_ff;
      if (step_en) begin
         if (last_byte) begin
            esc_in   = 1'b0;
            sq_in    = 1'b0;
            dq_in    = 1'b0;
            open_in  = 1'b0;
            args_in  = 4'd0;
            bytes_in = 6'd0;
            many_in  = 1'b0;
         end else begin
            esc_in   = esc_mid;
            sq_in    = sq_mid;
            dq_in    = dq_mid;
            open_in  = open_mid;
            args_in  = args_mid;
            bytes_in = bytes_mid;
            many_in  = many_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= 1'b0;
         sq_ff    <= 1'b0;
         dq_ff    <= 1'b0;
         open_ff  <= 1'b0;
         args_ff  <= 4'd0;
         bytes_ff <= 6'd0;
         many_ff  <= 1'b0;
      end else begin
         esc_ff   <= esc_in;
         sq_ff    <= sq_in;
         dq_ff    <= dq_in;
         open_ff  <= open_in;
         args_ff  <= args_in;
         bytes_ff <= bytes_in;
         many_ff  <= many_in;
      end
   end

   `CLT_ASSERT_NEVER(a_one_quote_kind, clock, reset, sq_ff && dq_ff)
   `CLT_ASSERT_NEXT(a_line_end_clears, clock, reset, step_en && last_byte,
                    args_ff == 4'd0 && bytes_ff == 6'd0 && !open_ff && !many_ff)
   `CLT_ASSERT_NEXT(a_args_monotonic, clock, reset, !(step_en && last_byte),
                    args_ff >= $past(args_ff))

endmodule

// File: hw/rtl/command_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits a command line, one byte per transaction, into shell-style arguments
// with single quotes, double quotes and backslash escapes.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                   handshake
//  req_chan  in         in_byte[7:0], last_byte                   valid/ready
//  rsp_chan  out        char_valid, out_char[7:0], arg_end,       valid/ready
//                       line_end, status[1:0], arg_count[3:0]
//  csr_*     in         csr_wr_data[3:0] = max_args               write enable
//
//  One transaction per cycle sustained while the response side is ready; a
//  request passes the input register, then the result register.
//  The only loop is the tokenizer state update in clt_core, one byte a cycle unless stalled.
//  Synchronous active-high reset clears the line state, the pipeline valids
//  and sets max_args to 11.
//  A stalled response holds the result register; the input register keeps
//  accepting as long as its content can move on in the same cycle.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_defines.svh"

module command_line_tokenizer #(
   parameter int LINE_BYTES = clt_pkg::LINE_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   clt_req_if.sink    req_chan,
   clt_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);
   import clt_pkg::*;

   // configuration register
   logic [3:0] max_args_ff;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   logic       req_take;
   logic       s1_advance;
   result_type step_result;

   // The stage moves forward whenever the result register is free or drains
   assign s1_advance = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (req_chan.ready) begin
         s1_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_ff  <= MAX_ARGS_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_args_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_chan.in_byte;
         s1_last_ff <= req_chan.last_byte;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_data_ff <= step_result;
      end
   end

   // tokenizer state steps exactly when a byte moves into the result register
   clt_core #(
      .LINE_BYTES (LINE_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (s1_valid_ff && s1_advance),
      .in_byte   (s1_byte_ff),
      .last_byte (s1_last_ff),
      .max_args  (max_args_ff),
      .result    (step_result)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.char_valid = rsp_data_ff.char_valid;
   assign rsp_chan.out_char   = rsp_data_ff.out_char;
   assign rsp_chan.arg_end    = rsp_data_ff.arg_end;
   assign rsp_chan.line_end   = rsp_data_ff.line_end;
   assign rsp_chan.status     = rsp_data_ff.status;
   assign rsp_chan.arg_count  = rsp_data_ff.arg_count;

   `CLT_ASSERT_NEVER(a_no_overwrite, clock, reset, req_take && s1_valid_ff && !s1_advance)
   `CLT_ASSERT_IMP(a_status_at_end, clock, reset,
                   rsp_valid_ff && rsp_data_ff.status != ST_OK, rsp_data_ff.line_end)
   `CLT_ASSERT_IMP(a_char_zero, clock, reset,
                   rsp_valid_ff && !rsp_data_ff.char_valid, rsp_data_ff.out_char == 8'd0)

endmodule

// File: bench/tb_command_line_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Streams command lines into the tokenizer one byte per transaction, predicts
// every per-byte result with an independent shell-style splitter, and checks
// the results in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_command_line_tokenizer;
   import clt_pkg::*;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } raw_byte_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [3:0] csr_wr_data;

   clt_req_if req_if ();
   clt_rsp_if rsp_if ();

   command_line_tokenizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Bytes waiting to be offered, and per-byte results waiting to arrive.
   raw_byte_type pending_q[$];
   result_type   expected_q[$];
   logic [7:0]   line_buf[$];
   int           queued_items = 0;
   int           arg_limit    = 11;

   // Splitter state mirrored from the block's outside behavior.
   logic       esc_pending;
   logic       in_squote;
   logic       in_dquote;
   logic       word_open;
   logic [3:0] words_done;
   logic [5:0] line_bytes;
   logic       over_limit;
   logic [3:0] arg_limit_model;

   // Handshake bookkeeping, sampled at the rising edge.
   logic req_took;
   logic rsp_took;
   int   results_seen = 0;
   int   fault_count  = 0;

   // Idle pacing for both channels; a busy side draws a gap per transaction.
   int   send_gap  = 0;
   int   take_wait = 0;
   bit   send_busy = 1'b1;
   bit   take_busy = 1'b1;
   int   hold_left = 0;
   bit   hold_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin : watchdog
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   task automatic clear_line_state();
      esc_pending = 1'b0;
      in_squote   = 1'b0;
      in_dquote   = 1'b0;
      word_open   = 1'b0;
      words_done  = '0;
      line_bytes  = '0;
      over_limit  = 1'b0;
   endtask

   // Close the current argument; the limit check sees the count before
   // saturation so a limit of 15 still works.
   task automatic close_word();
      if (words_done >= arg_limit_model) over_limit = 1'b1;
      if (words_done < ARG_COUNT_MAX) words_done = words_done + 4'd1;
      word_open = 1'b0;
   endtask

   task automatic tokenize_byte(input logic [7:0] b, input logic last,
                                output result_type r);
      logic keep;
      logic ended;
      logic open_q;
      keep  = 1'b0;
      ended = 1'b0;
      r     = '0;
      if (line_bytes < BYTE_COUNT_MAX) line_bytes = line_bytes + 6'd1;

      if (esc_pending) begin
         keep        = 1'b1;
         esc_pending = 1'b0;
      end else if (in_squote) begin
         // everything is literal up to the closing single quote
         if (b == CH_SQUOTE) in_squote = 1'b0;
         else keep = 1'b1;
      end else if (in_dquote) begin
         if (b == CH_DQUOTE) in_dquote = 1'b0;
         else if (b == CH_BSLASH) esc_pending = 1'b1;
         else keep = 1'b1;
      end else if (b == CH_BSLASH) begin
         esc_pending = 1'b1;
      end else if (b == CH_SQUOTE) begin
         in_squote = 1'b1;
      end else if (b == CH_DQUOTE) begin
         in_dquote = 1'b1;
      end else if (b == CH_SPACE) begin
         // unquoted space closes only a non-empty argument
         if (word_open) begin
            close_word();
            ended = 1'b1;
         end
      end else begin
         keep = 1'b1;
      end

      if (keep) word_open = 1'b1;

      r.status = ST_OK;
      if (last) begin
         open_q = esc_pending | in_squote | in_dquote;
         // an unterminated quote or escape leaves the argument unclosed
         if (!open_q && word_open) begin
            close_word();
            ended = 1'b1;
         end
         // too long wins over unterminated, which wins over too many
         if (line_bytes >= LINE_BYTES_DEFAULT) r.status = ST_TOO_LONG;
         else if (open_q) r.status = ST_OPEN;
         else if (over_limit) r.status = ST_TOO_MANY;
      end

      r.char_valid = keep;
      r.out_char   = keep ? b : 8'h00;
      r.arg_end    = ended;
      r.line_end   = last;
      r.arg_count  = words_done;
      if (last) clear_line_state();
   endtask

   // ---------------------------------------------------------------------
   // Rising edge: record handshakes, check results, predict new ones
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (reset) begin
         req_took <= 1'b0;
         rsp_took <= 1'b0;
         clear_line_state();
         arg_limit_model = MAX_ARGS_RESET;
      end else begin
         req_took <= req_if.valid && req_if.ready;
         rsp_took <= rsp_if.valid && rsp_if.ready;
         if (csr_wr_en) arg_limit_model = csr_wr_data;

         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            got.char_valid = rsp_if.char_valid;
            got.out_char   = rsp_if.out_char;
            got.arg_end    = rsp_if.arg_end;
            got.line_end   = rsp_if.line_end;
            got.status     = status_type'(rsp_if.status);
            got.arg_count  = rsp_if.arg_count;
            if (expected_q.size() == 0) begin
               if (fault_count < 10)
                  $display("[%0t] tokenizer result with nothing pending: cv=%0b ch=%02h",
                           $realtime, got.char_valid, got.out_char);
               fault_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.char_valid !== want.char_valid || got.out_char !== want.out_char ||
                   got.arg_end !== want.arg_end || got.line_end !== want.line_end ||
                   got.status !== want.status || got.arg_count !== want.arg_count) begin
                  if (fault_count < 10)
                     $display({"[%0t] tokenizer mismatch: expected cv=%0b ch=%02h end=%0b ",
                               "le=%0b st=%0d cnt=%0d, got cv=%0b ch=%02h end=%0b le=%0b ",
                               "st=%0d cnt=%0d"}, $realtime,
                              want.char_valid, want.out_char, want.arg_end, want.line_end,
                              want.status, want.arg_count,
                              got.char_valid, got.out_char, got.arg_end, got.line_end,
                              got.status, got.arg_count);
                  fault_count++;
               end
            end
         end

         if (req_if.valid && req_if.ready) begin
            tokenize_byte(req_if.in_byte, req_if.last_byte, want);
            expected_q.push_back(want);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Falling edge: byte driver. Advance to the next byte once the current
   // transaction went through, after the gap drawn for it.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_bytes
      raw_byte_type nxt;
      logic         offer;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_if.valid || req_took) begin
         offer = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_q.size() > 0) begin
            nxt   = pending_q.pop_front();
            offer = 1'b1;
            req_if.in_byte   <= nxt.value;
            req_if.last_byte <= nxt.last;
            // switch between idling and back-to-back stretches now and then
            if ($urandom_range(0, 39) == 0) send_busy = !send_busy;
            send_gap = send_busy ? $urandom_range(0, 17) : 0;
         end
         req_if.valid <= offer;
      end
   end

   // Result receiver: stall a drawn number of cycles after each transaction.
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 39) == 0) take_busy = !take_busy;
            take_wait = take_busy ? $urandom_range(0, 17) : 0;
         end else if (take_wait > 0) begin
            take_wait--;
         end
         rsp_if.ready <= (take_wait == 0) && (hold_left == 0);
      end
   end

   // Hold off the receiver once for a long stretch so the block backs up
   // and stalls its input while the driver keeps offering bytes.
   always @(negedge clock) begin : long_hold
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && results_seen >= 250) begin
         hold_left <= 120;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // Byte with no meaning to the splitter; at least half of them printable letters.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do begin
         b = $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                  : 8'($urandom_range(0, 255));
      end while (b == CH_BSLASH || b == CH_SQUOTE || b == CH_DQUOTE || b == CH_SPACE);
      return b;
   endfunction

   // Byte inside quotes, biased toward the special bytes; never the closer,
   // and never a bare backslash inside double quotes.
   function automatic logic [7:0] quoted_byte(input logic [7:0] closer);
      logic [7:0] b;
      do begin
         case ($urandom_range(0, 5))
            0: b = CH_SPACE;
            1: b = CH_BSLASH;
            2: b = CH_SQUOTE;
            3: b = CH_DQUOTE;
            default: b = 8'($urandom_range(0, 255));
         endcase
      end while (b == closer || (closer == CH_DQUOTE && b == CH_BSLASH));
      return b;
   endfunction

   // Move the line being built into the byte queue, flagging its last byte.
   task automatic push_line();
      raw_byte_type item;
      foreach (line_buf[i]) begin
         item.value = line_buf[i];
         item.last  = (i == line_buf.size() - 1);
         pending_q.push_back(item);
      end
      queued_items += line_buf.size();
      line_buf.delete();
   endtask

   // Hold until every byte went through and every result came back, then
   // let the pipeline drain.
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_if.valid || expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [3:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
      arg_limit = value;
   endtask

   // Queue random lines worth roughly budget bytes. Most lines are well formed
   // argument lists with random content; some end inside a quote or escape,
   // and some are raw noise. A few are long enough to hit the length limit.
   task automatic fill_phase(input int budget);
      int goal;
      int kind;
      int words;
      int k;
      bit lengthy;
      bit dense;
      goal = queued_items + budget;
      while (queued_items < goal) begin
         kind    = $urandom_range(0, 19);
         lengthy = ($urandom_range(0, 9) == 0);
         if (kind < 3) begin
            repeat (lengthy ? $urandom_range(30, 70) : $urandom_range(1, 12))
               line_buf.push_back($urandom_range(0, 1) ? quoted_byte(CH_SQUOTE)
                                                       : 8'($urandom_range(0, 255)));
         end else begin
            // dense lines pack many short arguments around the limit
            dense = ($urandom_range(0, 1) == 0);
            words = dense ? $urandom_range((arg_limit > 1) ? arg_limit - 1 : 0, arg_limit + 2)
                          : $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_SPACE);
            for (k = 0; k < words; k++) begin
               if (k > 0)
                  repeat (dense ? 1 : $urandom_range(1, 2)) line_buf.push_back(CH_SPACE);
               if (dense && $urandom_range(0, 3) != 0) begin
                  line_buf.push_back(plain_byte());
               end else begin
                  repeat (lengthy ? $urandom_range(2, 6) : $urandom_range(1, 3)) begin
                     case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: begin
                           repeat (lengthy ? $urandom_range(3, 9) : $urandom_range(1, 3))
                              line_buf.push_back(plain_byte());
                        end
                        5, 6: begin
                           // single quoted, possibly empty
                           line_buf.push_back(CH_SQUOTE);
                           repeat ($urandom_range(0, 3))
                              line_buf.push_back(quoted_byte(CH_SQUOTE));
                           line_buf.push_back(CH_SQUOTE);
                        end
                        7, 8: begin
                           // double quoted with occasional escapes
                           line_buf.push_back(CH_DQUOTE);
                           repeat ($urandom_range(0, 3)) begin
                              if ($urandom_range(0, 3) == 0) begin
                                 line_buf.push_back(CH_BSLASH);
                                 line_buf.push_back(8'($urandom_range(0, 255)));
                              end else begin
                                 line_buf.push_back(quoted_byte(CH_DQUOTE));
                              end
                           end
                           line_buf.push_back(CH_DQUOTE);
                        end
                        default: begin
                           line_buf.push_back(CH_BSLASH);
                           line_buf.push_back(8'($urandom_range(0, 255)));
                        end
                     endcase
                  end
               end
            end
            if ($urandom_range(0, 3) == 0) line_buf.push_back(CH_SPACE);
            // broken lines: leave a quote or escape hanging near the end
            if (kind < 6) begin
               case ($urandom_range(0, 2))
                  0: line_buf.push_back(CH_SQUOTE);
                  1: line_buf.push_back(CH_DQUOTE);
                  default: line_buf.push_back(CH_BSLASH);
               endcase
               if ($urandom_range(0, 1)) line_buf.push_back(plain_byte());
            end
         end
         if (line_buf.size() == 0) line_buf.push_back(CH_SPACE);
         push_line();
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_if.valid     = 1'b0;
      req_if.in_byte   = '0;
      req_if.last_byte = 1'b0;
      rsp_if.ready     = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines under the reset limit.
      // Zero and all-ones bytes, empty double quotes, a single quoted
      // backslash and double quote, an escaped quote inside double quotes,
      // and an escaped space as the last byte closing the final argument.
      line_buf = '{8'h00, 8'hFF, CH_SPACE, CH_DQUOTE, CH_DQUOTE, CH_SPACE,
                   CH_SQUOTE, CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_SPACE,
                   CH_DQUOTE, CH_BSLASH, CH_DQUOTE, 8'h41, CH_DQUOTE,
                   CH_BSLASH, CH_SPACE};
      push_line();
      // unterminated single quote, double quote and escape
      line_buf = '{CH_SQUOTE, 8'h7F};
      push_line();
      line_buf = '{CH_DQUOTE};
      push_line();
      line_buf = '{CH_BSLASH};
      push_line();

      // Limit of one: two arguments are one too many.
      write_cfg(4'd1);
      line_buf = '{8'h61, CH_SPACE, 8'h62};
      push_line();
      fill_phase(180);

      // Limit of 14, then four random ones from 2 to 13.
      write_cfg(4'd14);
      fill_phase(200);
      repeat (4) begin
         write_cfg(4'($urandom_range(2, 13)));
         fill_phase(190);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_q.size() != 0) fault_count++;
      if (fault_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
